// File: rtl/core/drit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drit_pkg
// Shared types and constants for the dirty rectangle island tracker.
// ----------------------------------------------------------------------------
package drit_pkg;

    // Clip edges saturate here; coordinates fit 12 bits, sizes 13 bits.
    localparam int MAX_DIM   = 4096;
    localparam int COORD_W   = 12;
    localparam int SIZE_W    = 13;
    localparam int ISLANDS_D = 8;

    localparam int IN_W      = 16;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_W    = 3;

    // Input kinds (tuser)
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } t_rect;

endpackage

`default_nettype wire

// File: rtl/core/drit_rect_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drit_rect_unit
// Touch test and bounding merge of two rectangles (edges inclusive).
// ----------------------------------------------------------------------------
module drit_rect_unit (
    input  wire drit_pkg::t_rect i_a,
    input  wire drit_pkg::t_rect i_b,
    output logic                 o_touch,
    output drit_pkg::t_rect      o_merged
);
    import drit_pkg::*;

    logic [SIZE_W-1:0] a_l, a_t, a_r, a_b;
    logic [SIZE_W-1:0] b_l, b_t, b_r, b_b;
    logic [SIZE_W-1:0] m_l, m_t, m_r, m_b;

    always_comb begin
        a_l = {1'b0, i_a.x};
        a_t = {1'b0, i_a.y};
        b_l = {1'b0, i_b.x};
        b_t = {1'b0, i_b.y};
        a_r = a_l + i_a.w;
        a_b = a_t + i_a.h;
        b_r = b_l + i_b.w;
        b_b = b_t + i_b.h;

        o_touch = (a_l <= b_r) && (b_l <= a_r) && (a_t <= b_b) && (b_t <= a_b);

        m_l = (a_l < b_l) ? a_l : b_l;
        m_t = (a_t < b_t) ? a_t : b_t;
        m_r = (a_r > b_r) ? a_r : b_r;
        m_b = (a_b > b_b) ? a_b : b_b;

        o_merged.x = m_l[COORD_W-1:0];
        o_merged.y = m_t[COORD_W-1:0];
        o_merged.w = m_r - m_l;
        o_merged.h = m_b - m_t;
    end

endmodule

`default_nettype wire

// File: rtl/core/dirty_rectangle_island_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dirty_rectangle_island_tracker
// Keeps a bounding box and a small table of disjoint damaged islands.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser selects mark (0) or
//   clear (1), tdata holds rect_x, rect_y, rect_w, rect_h (signed 16 each).
//   m_axis returns one result per island (or one all-zero island result when
//   the table is empty); tlast flags the final result of the command.
//   The user must make config writes (i_cfg_we/index/data) only between
//   commands; the block itself does not enforce this.
// Sequence:
//   Accept, clip and update are separate states. Island merging walks the
//   table in the island RAM: a read and a check state per slot visited,
//   plus a write state for each moved slot; every merge restarts the walk.
//   Append then writes the region, or the bounding box if the table is full.
//   Results leave through a RAM read state and an output load state each.
// Reset: clean state, no islands, image 4096x4096, tracking on. The island
//   RAM is not cleared; only slots below the island count are ever used.
// Stall: results sit in the output register until taken; the walk pauses
//   on the output stage, and a new command is accepted as soon as the last
//   result is loaded, even while it still waits downstream.
// ----------------------------------------------------------------------------
module dirty_rectangle_island_tracker #(
    parameter int ISLANDS = drit_pkg::ISLANDS_D
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // slave side
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] rect_x, [31:16] rect_y, [47:32] rect_w, [63:48] rect_h
    input  wire  [4*drit_pkg::IN_W-1:0]       s_axis_tdata,
    // [0] opcode
    input  wire                               s_axis_tuser,
    // master side
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [0] dirty, [12:1] bound_x, [24:13] bound_y, [37:25] bound_w,
    // [50:38] bound_h, [62:51] island_x, [74:63] island_y,
    // [87:75] island_w, [100:88] island_h, [103:101] island_slot
    output logic [103:0]                      m_axis_tdata,
    output logic                              m_axis_tlast,
    // configuration
    input  wire                               i_cfg_we,
    input  wire  [drit_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [drit_pkg::CFG_W-1:0]        i_cfg_data
);
    import drit_pkg::*;

    localparam int CNTW = $clog2(ISLANDS + 1);
    localparam int IDXW = (ISLANDS > 1) ? $clog2(ISLANDS) : 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLIP     = 4'd1;
    localparam logic [3:0] S_DECIDE   = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_MOVE_WR  = 4'd5;
    localparam logic [3:0] S_APPEND   = 4'd6;
    localparam logic [3:0] S_EMIT_RD  = 4'd7;
    localparam logic [3:0] S_EMIT_WR  = 4'd8;

    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(ISLANDS);
    localparam logic [CNTW-1:0] CNT_ONE  = CNTW'(1);

    // configuration
    logic [CFG_W-1:0] r_img_w, r_img_h;
    logic             r_track;

    // control / state
    logic [3:0]       r_state, n_state;
    logic             r_op;
    logic [IN_W-1:0]  r_x, r_y, r_w, r_h;
    t_rect            r_reg, n_reg;
    logic             r_mark_ok, n_mark_ok;
    logic             r_dirty, n_dirty;
    t_rect            r_bbox, n_bbox;
    logic [CNTW-1:0]  r_count, n_count;
    logic [CNTW-1:0]  r_idx, n_idx;

    // output stage
    logic             r_out_valid, n_out_valid;
    logic [103:0]     r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    // island RAM
    t_rect            r_mem [ISLANDS];
    t_rect            r_rd_data;
    logic [CNTW-1:0]  rd_cnt;
    logic             mem_we;
    logic [CNTW-1:0]  wr_cnt;
    t_rect            wr_data;

    // rectangle unit
    t_rect            ru_b, ru_merged;
    logic             ru_touch;

    // clip datapath
    logic signed [17:0] c_x, c_y, c_w, c_h, c_r, c_b, c_l, c_t, c_wl, c_hl;
    logic               c_ok;
    t_rect              c_rect;

    // emit helpers
    logic [CNTW+SLOT_W-1:0] slot_ext;
    t_rect                  isl;
    logic                   is_last;
    logic                   out_free;

    drit_rect_unit u_rect (
        .i_a      (r_reg),
        .i_b      (ru_b),
        .o_touch  (ru_touch),
        .o_merged (ru_merged)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Clip to the image, with the clip edge saturated at MAX_DIM.
    always_comb begin
        c_x  = 18'(signed'(r_x));
        c_y  = 18'(signed'(r_y));
        c_w  = 18'(signed'(r_w));
        c_h  = 18'(signed'(r_h));
        c_wl = (r_img_w > CFG_W'(MAX_DIM)) ? 18'(MAX_DIM) : 18'(r_img_w);
        c_hl = (r_img_h > CFG_W'(MAX_DIM)) ? 18'(MAX_DIM) : 18'(r_img_h);
        c_l  = (c_x > 18'sd0) ? c_x : 18'sd0;
        c_t  = (c_y > 18'sd0) ? c_y : 18'sd0;
        c_r  = ((c_x + c_w) < c_wl) ? (c_x + c_w) : c_wl;
        c_b  = ((c_y + c_h) < c_hl) ? (c_y + c_h) : c_hl;
        c_ok = r_track && (c_w > 18'sd0) && (c_h > 18'sd0) && (c_r > c_l) && (c_b > c_t);
        c_rect.x = c_l[COORD_W-1:0];
        c_rect.y = c_t[COORD_W-1:0];
        c_rect.w = SIZE_W'(c_r - c_l);
        c_rect.h = SIZE_W'(c_b - c_t);
    end

    // Emit fields
    always_comb begin
        slot_ext = {{SLOT_W{1'b0}}, r_idx};
        isl      = (r_count == '0) ? '0 : r_rd_data;
        is_last  = (r_count == '0) || (r_idx == (r_count - CNT_ONE));
        out_free = !r_out_valid || m_axis_tready;
    end

    always_comb begin
        n_state     = r_state;
        n_reg       = r_reg;
        n_mark_ok   = r_mark_ok;
        n_dirty     = r_dirty;
        n_bbox      = r_bbox;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        rd_cnt      = r_idx;
        mem_we      = 1'b0;
        wr_cnt      = r_idx;
        wr_data     = r_reg;
        ru_b        = r_rd_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_CLIP;
                end
            end
            S_CLIP: begin
                n_reg     = c_rect;
                n_mark_ok = c_ok;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                ru_b  = r_bbox;
                n_idx = '0;
                if (r_op == OP_CLEAR) begin
                    n_dirty = 1'b0;
                    n_bbox  = '0;
                    n_count = '0;
                    n_state = S_EMIT_RD;
                end else if (!r_mark_ok) begin
                    n_state = S_EMIT_RD;
                end else if (!r_dirty) begin
                    // first damage: box and slot 0 are the region itself
                    n_dirty = 1'b1;
                    n_bbox  = r_reg;
                    n_count = CNT_ONE;
                    mem_we  = 1'b1;
                    wr_cnt  = '0;
                    wr_data = r_reg;
                    n_state = S_EMIT_RD;
                end else begin
                    n_bbox  = ru_merged;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                rd_cnt = r_idx;
                if (r_idx < r_count) begin
                    n_state = S_SCAN_CHK;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_SCAN_CHK: begin
                // read the last live slot in case it must fill a hole
                rd_cnt = r_count - CNT_ONE;
                if (ru_touch) begin
                    n_reg   = ru_merged;
                    n_count = r_count - CNT_ONE;
                    if (r_idx != (r_count - CNT_ONE)) begin
                        n_state = S_MOVE_WR;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_idx   = r_idx + CNT_ONE;
                    n_state = S_SCAN_RD;
                end
            end
            S_MOVE_WR: begin
                mem_we  = 1'b1;
                wr_cnt  = r_idx;
                wr_data = r_rd_data;
                n_idx   = '0;
                n_state = S_SCAN_RD;
            end
            S_APPEND: begin
                mem_we = 1'b1;
                if (r_count < CNT_FULL) begin
                    wr_cnt  = r_count;
                    wr_data = r_reg;
                    n_count = r_count + CNT_ONE;
                end else begin
                    // table full: collapse to the bounding box
                    wr_cnt  = '0;
                    wr_data = r_bbox;
                    n_count = CNT_ONE;
                end
                n_idx   = '0;
                n_state = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                rd_cnt  = r_idx;
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = is_last;
                    n_out_data  = {slot_ext[SLOT_W-1:0], isl.h, isl.w, isl.y, isl.x,
                                   r_bbox.h, r_bbox.w, r_bbox.y, r_bbox.x, r_dirty};
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_ONE;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Island RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_cnt[IDXW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_cnt[IDXW-1:0]];
    end

    // Input capture and datapath registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op <= s_axis_tuser;
            r_x  <= s_axis_tdata[IN_W-1:0];
            r_y  <= s_axis_tdata[2*IN_W-1:IN_W];
            r_w  <= s_axis_tdata[3*IN_W-1:2*IN_W];
            r_h  <= s_axis_tdata[4*IN_W-1:3*IN_W];
        end
        r_reg      <= n_reg;
        r_mark_ok  <= n_mark_ok;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= 1'b0;
            r_bbox      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_img_w     <= CFG_W'(MAX_DIM);
            r_img_h     <= CFG_W'(MAX_DIM);
            r_track     <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_dirty     <= n_dirty;
            r_bbox      <= n_bbox;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IMG_W: r_img_w <= i_cfg_data;
                    CFG_IMG_H: r_img_h <= i_cfg_data;
                    CFG_TRACK: r_track <= i_cfg_data[0];
                    default:   r_track <= r_track;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
